// File: src/visible_escape_line_wrapper_defines.svh
// Assertion macros used by the checker file of the visible escape block.
// Holds only macro definitions; no dependencies.
`ifndef VISIBLE_ESCAPE_LINE_WRAPPER_DEFINES_SVH
`define VISIBLE_ESCAPE_LINE_WRAPPER_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define VEL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define VEL_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/vel_pkg.sv
// Package of the visible escape line block: character codes, word types and
// the byte expansion function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vel_pkg;

  localparam logic [7:0] DEFAULT_WRAP = 8'd72;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOL  = 1'b1;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic [2:0] LEN_PLAIN  = 3'd1;
  localparam logic [2:0] LEN_LETTER = 3'd2;
  localparam logic [2:0] LEN_OCTAL  = 3'd4;
  localparam logic [2:0] LEN_WRAP   = 3'd2;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } exp_t;

  typedef struct packed {
    logic [2:0]      count;
    logic [5:0][7:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_msg_t;

  function automatic exp_t expand_byte(input logic [7:0] c);
    exp_t e;
    logic [7:0] letter;
    e.bytes = '0;
    e.len = LEN_PLAIN;
    unique case (c)
      CH_BSLASH: letter = CH_BSLASH;
      CH_BEL:    letter = CH_A;
      CH_BS:     letter = CH_B;
      CH_FF:     letter = CH_F;
      CH_LF:     letter = CH_N;
      CH_CR:     letter = CH_R;
      CH_TAB:    letter = CH_T;
      CH_VT:     letter = CH_V;
      default:   letter = '0;
    endcase
    if (letter != '0) begin
      e.bytes[0] = CH_BSLASH;
      e.bytes[1] = letter;
      e.len = LEN_LETTER;
    end else if (c < CH_SPACE || c > CH_TILDE) begin
      e.bytes[0] = CH_BSLASH;
      e.bytes[1] = CH_ZERO + {6'b0, c[7:6]};
      e.bytes[2] = CH_ZERO + {5'b0, c[5:3]};
      e.bytes[3] = CH_ZERO + {5'b0, c[2:0]};
      e.len = LEN_OCTAL;
    end else begin
      e.bytes[0] = c;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// File: src/vel_queue.sv
// Short queue of expansion words between the front and the emit stage.
// Depends on vel_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module vel_queue #(
  parameter int DEPTH = vel_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire               clk,
  input  wire               rst,
  input  vel_pkg::cmd_msg_t wr,
  output logic              full,
  input  wire               rd_pop,
  output vel_pkg::cmd_msg_t rd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vel_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign do_wr = wr.valid && !full;
  assign do_rd = rd_pop && (count != '0);

  assign rd.valid = (count != '0);
  assign rd.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr.cmd;
    end
  end

endmodule

`default_nettype wire

// File: src/vel_front.sv
// Front stage: classifies each input word, keeps the column count and the
// wrap width, and builds the full output word sequence. Depends on vel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vel_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [7:0]         cfg_wdata,
  input  wire               push,
  input  wire               q_full,
  input  wire               req_type,
  input  wire [7:0]         line_byte,
  output vel_pkg::cmd_msg_t wr
);

  logic [7:0] wrap_width;
  logic [7:0] column;
  logic [7:0] column_next;
  logic [8:0] col_sum;
  logic       wrap;
  logic       accept;
  vel_pkg::exp_t exp_w;

  assign accept  = push && !q_full;
  assign exp_w   = vel_pkg::expand_byte(line_byte);
  assign col_sum = {1'b0, column} + {6'b0, exp_w.len};
  assign wrap    = (col_sum >= {1'b0, wrap_width});

  always_comb begin
    wr.valid = accept;
    wr.cmd.bytes = '0;
    if (req_type == vel_pkg::REQ_EOL) begin
      wr.cmd.bytes[0] = vel_pkg::CH_DOLLAR;
      wr.cmd.bytes[1] = vel_pkg::CH_LF;
      wr.cmd.count = 3'd2;
      column_next = '0;
    end else if (wrap) begin
      wr.cmd.bytes[0] = vel_pkg::CH_BSLASH;
      wr.cmd.bytes[1] = vel_pkg::CH_LF;
      wr.cmd.bytes[5:2] = exp_w.bytes;
      wr.cmd.count = exp_w.len + vel_pkg::LEN_WRAP;
      column_next = {5'b0, exp_w.len};
    end else begin
      wr.cmd.bytes[3:0] = exp_w.bytes;
      wr.cmd.count = exp_w.len;
      column_next = col_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width <= vel_pkg::DEFAULT_WRAP;
      column     <= '0;
    end else begin
      if (cfg_we) begin
        wrap_width <= cfg_wdata;
      end
      if (accept) begin
        column <= column_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/vel_emit.sv
// Back stage: holds the current expansion word sequence and hands out one
// output word per cycle while pop is high. Depends on vel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vel_emit (
  input  wire               clk,
  input  wire               rst,
  input  vel_pkg::cmd_msg_t rd,
  output logic              rd_pop,
  input  wire               pop,
  output logic              empty,
  output logic [7:0]        out_byte,
  output logic              last_of_run
);

  vel_pkg::cmd_t cur;
  logic          cur_valid;
  logic [2:0]    idx;
  logic          take;

  assign empty       = !cur_valid;
  assign out_byte    = cur.bytes[idx];
  assign last_of_run = (idx == cur.count - 3'd1);
  assign take        = pop && cur_valid;
  assign rd_pop      = rd.valid && (!cur_valid || (take && last_of_run));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (rd_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (last_of_run) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pop) begin
      cur <= rd.cmd;
    end
  end

endmodule

`default_nettype wire

// File: src/visible_escape_line_wrapper.sv
// Top level of the visible escape line block: front stage, word queue and
// emit stage. Depends on vel_pkg, vel_front, vel_queue and vel_emit.
//
//   channel  handshake        payload
//   input    push / full      req_type, line_byte
//   output   pop / empty      out_byte, last_of_run
//   config   cfg_we           cfg_wdata (wrap width)
//
// An input word is classified and queued in its accept cycle; its first
// output word passes through the queue entry and the emit stage's current
// word register, further output words follow one per cycle while pop is
// high, and an input word expands into 1 to 6 words, handed out singly.
// Reset clears the queue, the column count and sets the wrap width to 72.
// Full rises only when the queue of QUEUE_DEPTH words is occupied.
`timescale 1ns / 1ps
`default_nettype none

module visible_escape_line_wrapper #(
  parameter int QUEUE_DEPTH = vel_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [7:0]  cfg_wdata,
  input  wire        push,
  output logic       full,
  input  wire        req_type,
  input  wire [7:0]  line_byte,
  input  wire        pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  vel_pkg::cmd_msg_t q_wr;
  vel_pkg::cmd_msg_t q_rd;
  logic              q_full;
  logic              q_pop;

  assign full = q_full;

  vel_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .q_full    (q_full),
    .req_type  (req_type),
    .line_byte (line_byte),
    .wr        (q_wr)
  );

  vel_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .full   (q_full),
    .rd_pop (q_pop),
    .rd     (q_rd)
  );

  vel_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .rd          (q_rd),
    .rd_pop      (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// File: src/vel_checker.sv
// Port-level checker for the visible escape line block, bound to the top
// level. Depends on visible_escape_line_wrapper_defines.svh and vel_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "visible_escape_line_wrapper_defines.svh"

module vel_checker (
  input wire       clk,
  input wire       rst,
  input wire       full,
  input wire       pop,
  input wire       empty,
  input wire [7:0] out_byte,
  input wire       last_of_run
);

  `VEL_ASSERT_RST(a_reset_empty, clk, rst |=> (empty && !full), "not idle after reset")

  `VEL_ASSERT(a_stall_hold, clk, rst,
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)),
    "stalled word changed")

  `VEL_ASSERT(a_run_continues, clk, rst, (!empty && pop && !last_of_run) |=> !empty, "run broken")

  `VEL_ASSERT(a_eol_pair, clk, rst,
    (!empty && pop && !last_of_run && out_byte == vel_pkg::CH_DOLLAR)
      |=> (out_byte == vel_pkg::CH_LF && last_of_run),
    "end of line not closed")

endmodule

bind visible_escape_line_wrapper vel_checker u_vel_checker (.*);

`default_nettype wire

// File: tb/sv/visible_escape_line_wrapper_tb.sv
// Self-checking testbench of the visible escape line block: drives text lines
// and wrap width settings, predicts every output word and checks it in order.
// Depends on vel_pkg and the visible_escape_line_wrapper RTL.
`timescale 1ns / 1ps

import vel_pkg::*;

class escape_scoreboard;
  logic [7:0] expected_chars[$];
  logic       expected_lasts[$];
  logic [7:0] wrap_width;
  logic [7:0] column;
  int         mismatches;

  function new();
    wrap_width = DEFAULT_WRAP;
    column = 8'd0;
    mismatches = 0;
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction

  function void note_input(logic rq, logic [7:0] c);
    logic [7:0] visible[$];
    logic [7:0] letter;
    int len;
    if (rq == REQ_EOL) begin
      expected_chars.push_back(CH_DOLLAR);
      expected_lasts.push_back(1'b0);
      expected_chars.push_back(CH_LF);
      expected_lasts.push_back(1'b1);
      column = 8'd0;
      return;
    end
    case (c)
      CH_BSLASH: letter = CH_BSLASH;
      CH_BEL:    letter = CH_A;
      CH_BS:     letter = CH_B;
      CH_FF:     letter = CH_F;
      CH_LF:     letter = CH_N;
      CH_CR:     letter = CH_R;
      CH_TAB:    letter = CH_T;
      CH_VT:     letter = CH_V;
      default:   letter = 8'd0;
    endcase
    if (letter != 8'd0) begin
      visible.push_back(CH_BSLASH);
      visible.push_back(letter);
    end else if (c < CH_SPACE || c > CH_TILDE) begin
      visible.push_back(CH_BSLASH);
      visible.push_back(CH_ZERO + {6'd0, c[7:6]});
      visible.push_back(CH_ZERO + {5'd0, c[5:3]});
      visible.push_back(CH_ZERO + {5'd0, c[2:0]});
    end else begin
      visible.push_back(c);
    end
    len = visible.size();
    if (int'(column) + len >= int'(wrap_width)) begin
      expected_chars.push_back(CH_BSLASH);
      expected_lasts.push_back(1'b0);
      expected_chars.push_back(CH_LF);
      expected_lasts.push_back(1'b0);
      column = len[7:0];
    end else begin
      column = column + len[7:0];
    end
    for (int i = 0; i < len; i++) begin
      expected_chars.push_back(visible[i]);
      expected_lasts.push_back(i == len - 1);
    end
  endfunction

  function void check_word(logic [7:0] ch, logic last);
    logic [7:0] want_ch;
    logic want_last;
    if (expected_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected word: out_byte %h last_of_run %b", ch, last);
      return;
    end
    want_ch = expected_chars.pop_front();
    want_last = expected_lasts.pop_front();
    if (ch !== want_ch || last !== want_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Word mismatch: expected out_byte %h last_of_run %b, got %h %b",
                 want_ch, want_last, ch, last);
    end
  endfunction
endclass

module visible_escape_line_wrapper_tb;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       push = 1'b0;
  logic       req_type = 1'b0;
  logic [7:0] line_byte = 8'd0;
  logic       pop = 1'b0;
  wire        full;
  wire        empty;
  wire  [7:0] out_byte;
  wire        last_of_run;

  escape_scoreboard sb;
  int  send_idle_pct = 18;
  int  recv_idle_pct = 70;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  logic [7:0] ctrl_chars[8] = '{CH_BSLASH, CH_BEL, CH_BS, CH_FF, CH_LF, CH_CR,
                                CH_TAB, CH_VT};

  visible_escape_line_wrapper dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .push(push),
    .full(full),
    .req_type(req_type),
    .line_byte(line_byte),
    .pop(pop),
    .empty(empty),
    .out_byte(out_byte),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_input(req_type, line_byte);
      if (pop && !empty) sb.check_word(out_byte, last_of_run);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic rq, input logic [7:0] c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    req_type <= rq;
    line_byte <= c;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic drain_and_set_wrap(input logic [7:0] width);
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= width;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.wrap_width = width;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'($urandom_range(255));
      4, 5, 6, 7: return 8'($urandom_range(CH_TILDE, CH_SPACE));
      default:    return ctrl_chars[$urandom_range(7)];
    endcase
  endfunction

  task automatic run_lines(input int n_words, input int max_line);
    int sent;
    int len;
    sent = 0;
    while (sent < n_words) begin
      len = $urandom_range(max_line);
      for (int j = 0; j < len && sent < n_words; j++) begin
        send_word(REQ_BYTE, pick_char());
        sent++;
      end
      if (sent < n_words) begin
        send_word(REQ_EOL, 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every escape class at the reset wrap width of 72.
    foreach (ctrl_chars[i]) send_word(REQ_BYTE, ctrl_chars[i]);
    send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, 8'h1F);
    send_word(REQ_BYTE, CH_SPACE);
    send_word(REQ_BYTE, CH_TILDE);
    send_word(REQ_BYTE, 8'h7F);
    send_word(REQ_BYTE, 8'h80);
    send_word(REQ_BYTE, 8'hFF);
    send_word(REQ_EOL, 8'hFF);

    // A zero width wraps before every byte.
    drain_and_set_wrap(8'd0);
    send_word(REQ_BYTE, 8'h41);
    send_word(REQ_EOL, 8'h00);
    // Tiny widths wrap even at column zero.
    drain_and_set_wrap(8'd1);
    send_word(REQ_BYTE, 8'h41);
    send_word(REQ_BYTE, CH_TAB);
    drain_and_set_wrap(8'd2);
    send_word(REQ_BYTE, CH_BSLASH);
    send_word(REQ_EOL, 8'h00);
    drain_and_set_wrap(8'd4);
    send_word(REQ_BYTE, 8'h01);

    drain_and_set_wrap(8'($urandom_range(12, 3)));
    run_lines(107, 20);

    drain_and_set_wrap(8'd255);
    send_idle_pct = 70;
    recv_idle_pct = 18;
    run_lines(107, 110);

    drain_and_set_wrap(DEFAULT_WRAP);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_lines(106, 60);

    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.mismatches++;
      $display("Words never produced: %0d", sb.pending());
    end
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
